### design/hmq_pkg.sv
// Shared codes and fixed widths for the indexed min-heap block.
package hmq_pkg;

  // Id space is fixed by the id field width
  localparam int ID_W     = 10;
  localparam int ID_SPACE = 1024;

  // Fixed result field widths
  localparam int OKEY_W  = 32;
  localparam int IKEY_W  = 32;
  localparam int OCNT_W  = 11;
  localparam int STAT_W  = 3;
  localparam int ACT_W   = 2;

  // Request codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEC    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ABSENT    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_PRESENT   = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NOT_LESS  = 3'd5;

endpackage

### design/indexed_min_heap_decrease_key_top.sv
// Top level of the indexed min-heap priority queue with decrease-key.
//
//   channel | handshake           | payload
//   in      | in_valid / in_stall | action, item_id, key
//   out     | out_valid/out_stall | out_id, out_key, count, is_empty, status
//
// One request at a time. Decode in S_MAP (then S_DK, or S_P1/S_P2 for a pop).
// A sift: S_SU_RD, S_SU_CMP per level up; S_SD_RL, S_SD_RR, S_SD_CMP per level down.
// Result: S_FIN, S_FIN2. After reset the id map is swept with in_stall high.
// A result waiting under out_stall holds the sequencer in its last step.
module indexed_min_heap_decrease_key_top
  import hmq_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ACT_W-1:0]   action,
  input  logic [ID_W-1:0]    item_id,
  input  logic [IKEY_W-1:0]  key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ID_W-1:0]    out_id,
  output logic [OKEY_W-1:0]  out_key,
  output logic [OCNT_W-1:0]  count,
  output logic               is_empty,
  output logic [STAT_W-1:0]  status
);

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int HW = ID_W + KEY_WIDTH;
  localparam int MW = 1 + PW;

  logic          h_we, h_re, m_we, m_re;
  logic [PW-1:0] h_waddr, h_raddr;
  logic [HW-1:0] h_wdata, h_rdata;
  logic [ID_W-1:0] m_waddr, m_raddr;
  logic [MW-1:0] m_wdata, m_rdata;

  hmq_ctrl #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .action, .item_id, .key,
    .out_valid, .out_stall, .out_id, .out_key, .count, .is_empty, .status,
    .h_we, .h_waddr, .h_wdata, .h_re, .h_raddr, .h_rdata,
    .m_we, .m_waddr, .m_wdata, .m_re, .m_raddr, .m_rdata
  );

  // Heap entries {id, key} by position
  hmq_ram #(.W(HW), .D(CAPACITY)) u_heap (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .re(h_re), .raddr(h_raddr), .rdata(h_rdata)
  );

  // Id map {present, position}
  hmq_ram #(.W(MW), .D(ID_SPACE)) u_map (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .re(m_re), .raddr(m_raddr), .rdata(m_rdata)
  );

endmodule

### design/hmq_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module hmq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/hmq_ctrl.sv
// Sequencer: request decode, sift up/down over the heap RAM, map upkeep, result register.
module hmq_ctrl
  import hmq_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32,
  parameter int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW = $clog2(CAPACITY + 1),
  parameter int HW = ID_W + KEY_WIDTH,
  parameter int MW = 1 + PW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACT_W-1:0]     action,
  input  logic [ID_W-1:0]      item_id,
  input  logic [IKEY_W-1:0]    key,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ID_W-1:0]      out_id,
  output logic [OKEY_W-1:0]    out_key,
  output logic [OCNT_W-1:0]    count,
  output logic                 is_empty,
  output logic [STAT_W-1:0]    status,
  output logic                 h_we,
  output logic [PW-1:0]        h_waddr,
  output logic [HW-1:0]        h_wdata,
  output logic                 h_re,
  output logic [PW-1:0]        h_raddr,
  input  logic [HW-1:0]        h_rdata,
  output logic                 m_we,
  output logic [ID_W-1:0]      m_waddr,
  output logic [MW-1:0]        m_wdata,
  output logic                 m_re,
  output logic [ID_W-1:0]      m_raddr,
  input  logic [MW-1:0]        m_rdata
);

  localparam int XW = PW + 1;
  localparam int SW = 4;

  localparam logic [SW-1:0] S_CLR    = 4'd0;
  localparam logic [SW-1:0] S_IDLE   = 4'd1;
  localparam logic [SW-1:0] S_MAP    = 4'd2;
  localparam logic [SW-1:0] S_DK     = 4'd3;
  localparam logic [SW-1:0] S_P1     = 4'd4;
  localparam logic [SW-1:0] S_P2     = 4'd5;
  localparam logic [SW-1:0] S_SU_RD  = 4'd6;
  localparam logic [SW-1:0] S_SU_CMP = 4'd7;
  localparam logic [SW-1:0] S_SD_RL  = 4'd8;
  localparam logic [SW-1:0] S_SD_RR  = 4'd9;
  localparam logic [SW-1:0] S_SD_CMP = 4'd10;
  localparam logic [SW-1:0] S_FIN    = 4'd11;
  localparam logic [SW-1:0] S_FIN2   = 4'd12;

  logic [SW-1:0]        state, state_next;
  logic [ID_W-1:0]      clr, clr_next;
  logic [ACT_W-1:0]     act, act_next;
  logic [ID_W-1:0]      id_r, id_r_next;
  logic [KEY_WIDTH-1:0] key_r, key_r_next;
  logic [PW-1:0]        pos, pos_next;
  logic [CW-1:0]        cnt, cnt_next;
  logic [ID_W-1:0]      e_id, e_id_next;
  logic [KEY_WIDTH-1:0] e_key, e_key_next;
  logic [HW-1:0]        lch, lch_next;
  logic [ID_W-1:0]      res_id, res_id_next;
  logic [OKEY_W-1:0]    res_key, res_key_next;
  logic                 own_id, own_id_next;
  logic                 own_key, own_key_next;
  logic [STAT_W-1:0]    stat, stat_next;
  logic                 ov_next;
  logic                 load_out;

  // Views of RAM data and tree indexes
  logic                 m_pres;
  logic [PW-1:0]        m_pos;
  logic [ID_W-1:0]      rd_id, l_id;
  logic [KEY_WIDTH-1:0] rd_key, l_key, best_key;
  logic [PW-1:0]        par;
  logic [XW-1:0]        lc, rc, cnt_x;
  logic                 l_win, r_win, r_ok;
  logic                 nonempty;
  logic [KEY_WIDTH-1:0] key_in;

  assign m_pres = m_rdata[MW-1];
  assign m_pos  = m_rdata[PW-1:0];
  assign rd_id  = h_rdata[HW-1:KEY_WIDTH];
  assign rd_key = h_rdata[KEY_WIDTH-1:0];
  assign l_id   = lch[HW-1:KEY_WIDTH];
  assign l_key  = lch[KEY_WIDTH-1:0];
  assign par    = (pos - PW'(1)) >> 1;
  assign lc     = {pos, 1'b0} + XW'(1);
  assign rc     = lc + XW'(1);
  assign cnt_x  = XW'(cnt);
  assign r_ok   = rc < cnt_x;
  assign l_win  = l_key < e_key;
  assign best_key = l_win ? l_key : e_key;
  assign r_win  = r_ok && (rd_key < best_key);
  assign nonempty = cnt != '0;
  assign key_in = KEY_WIDTH'(key);

  assign in_stall = state != S_IDLE;
  assign load_out = (state == S_FIN2) && (!out_valid || !out_stall);

  // Sequencer
  always_comb begin
    state_next   = state;
    clr_next     = clr;
    act_next     = act;
    id_r_next    = id_r;
    key_r_next   = key_r;
    pos_next     = pos;
    cnt_next     = cnt;
    e_id_next    = e_id;
    e_key_next   = e_key;
    lch_next     = lch;
    res_id_next  = res_id;
    res_key_next = res_key;
    own_id_next  = own_id;
    own_key_next = own_key;
    stat_next    = stat;
    h_we    = 1'b0;
    h_waddr = pos;
    h_wdata = {e_id, e_key};
    h_re    = 1'b0;
    h_raddr = '0;
    m_we    = 1'b0;
    m_waddr = e_id;
    m_wdata = {1'b1, pos};
    m_re    = 1'b0;
    m_raddr = item_id;
    case (state)
      S_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr;
        m_wdata = '0;
        clr_next = clr + ID_W'(1);
        if (clr == ID_W'(ID_SPACE - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          m_re         = 1'b1;
          act_next     = action;
          id_r_next    = item_id;
          key_r_next   = key_in;
          own_id_next  = 1'b0;
          own_key_next = 1'b0;
          stat_next    = STAT_OK;
          state_next   = S_MAP;
        end
      end
      S_MAP: begin
        case (act)
          ACT_INSERT: begin
            if (m_pres) begin
              stat_next  = STAT_PRESENT;
              state_next = S_FIN;
            end else if (cnt == CW'(CAPACITY)) begin
              stat_next  = STAT_FULL;
              state_next = S_FIN;
            end else begin
              pos_next   = PW'(cnt);
              cnt_next   = cnt + CW'(1);
              e_id_next  = id_r;
              e_key_next = key_r;
              state_next = S_SU_RD;
            end
          end
          ACT_POP: begin
            if (!nonempty) begin
              stat_next  = STAT_POP_EMPTY;
              state_next = S_FIN;
            end else begin
              h_re       = 1'b1;
              h_raddr    = '0;
              state_next = S_P1;
            end
          end
          default: begin
            if (!m_pres || (CW'(m_pos) >= cnt)) begin
              stat_next  = STAT_ABSENT;
              state_next = S_FIN;
            end else begin
              h_re       = 1'b1;
              h_raddr    = m_pos;
              pos_next   = m_pos;
              state_next = S_DK;
            end
          end
        endcase
      end
      S_DK: begin
        if (act == ACT_QUERY) begin
          res_key_next = OKEY_W'(rd_key);
          own_key_next = 1'b1;
          state_next   = S_FIN;
        end else if (key_r < rd_key) begin
          e_id_next  = id_r;
          e_key_next = key_r;
          state_next = S_SU_RD;
        end else begin
          stat_next  = STAT_NOT_LESS;
          state_next = S_FIN;
        end
      end
      // Root captured, its id leaves the map, fetch the last entry
      S_P1: begin
        res_id_next  = rd_id;
        res_key_next = OKEY_W'(rd_key);
        own_id_next  = 1'b1;
        own_key_next = 1'b1;
        m_we    = 1'b1;
        m_waddr = rd_id;
        m_wdata = '0;
        cnt_next = cnt - CW'(1);
        h_re    = 1'b1;
        h_raddr = PW'(cnt - CW'(1));
        state_next = S_P2;
      end
      S_P2: begin
        if (nonempty) begin
          e_id_next  = rd_id;
          e_key_next = rd_key;
          pos_next   = '0;
          state_next = S_SD_RL;
        end else begin
          state_next = S_FIN;
        end
      end
      // Sift up: the moving entry rides in e_id/e_key, parents move down into the hole
      S_SU_RD: begin
        if (pos == '0) begin
          h_we = 1'b1;
          m_we = 1'b1;
          state_next = S_FIN;
        end else begin
          h_re    = 1'b1;
          h_raddr = par;
          state_next = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        if (rd_key > e_key) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          m_we    = 1'b1;
          m_waddr = rd_id;
          pos_next   = par;
          state_next = S_SU_RD;
        end else begin
          h_we = 1'b1;
          m_we = 1'b1;
          state_next = S_FIN;
        end
      end
      // Sift down: read left, then right, then pick the smaller child
      S_SD_RL: begin
        if (lc >= cnt_x) begin
          h_we = 1'b1;
          m_we = 1'b1;
          state_next = S_FIN;
        end else begin
          h_re    = 1'b1;
          h_raddr = PW'(lc);
          state_next = S_SD_RR;
        end
      end
      S_SD_RR: begin
        lch_next = h_rdata;
        if (rc < cnt_x) begin
          h_re    = 1'b1;
          h_raddr = PW'(rc);
        end
        state_next = S_SD_CMP;
      end
      S_SD_CMP: begin
        if (r_win) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          m_we    = 1'b1;
          m_waddr = rd_id;
          pos_next   = PW'(rc);
          state_next = S_SD_RL;
        end else if (l_win) begin
          h_we    = 1'b1;
          h_wdata = lch;
          m_we    = 1'b1;
          m_waddr = l_id;
          pos_next   = PW'(lc);
          state_next = S_SD_RL;
        end else begin
          h_we = 1'b1;
          m_we = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        h_re    = 1'b1;
        h_raddr = '0;
        state_next = S_FIN2;
      end
      S_FIN2: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      cnt   <= cnt_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    act     <= act_next;
    id_r    <= id_r_next;
    key_r   <= key_r_next;
    pos     <= pos_next;
    e_id    <= e_id_next;
    e_key   <= e_key_next;
    lch     <= lch_next;
    res_id  <= res_id_next;
    res_key <= res_key_next;
    own_id  <= own_id_next;
    own_key <= own_key_next;
    stat    <= stat_next;
  end

  // Result register
  assign ov_next = load_out | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_id   <= own_id ? res_id : (nonempty ? rd_id : '0);
      out_key  <= own_key ? res_key : (nonempty ? OKEY_W'(rd_key) : '0);
      count    <= OCNT_W'(cnt);
      is_empty <= !nonempty;
      status   <= stat;
    end
  end

endmodule

### design/hmq_checker.sv
// Port-level checks for the indexed min-heap, bound to the top level.
module hmq_checker
  import hmq_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [ID_W-1:0]   out_id,
  input logic [OKEY_W-1:0] out_key,
  input logic [OCNT_W-1:0] count,
  input logic              is_empty,
  input logic [STAT_W-1:0] status
);

  // Empty flag agrees with the count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == '0)))
    else $error("is_empty disagrees with count");

  // Failed pop reports an empty heap and zero payload
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_POP_EMPTY) |-> (is_empty && out_id == '0 && out_key == '0))
    else $error("pop on empty heap with nonzero result");

  // Only one request in flight: input stalls right after a transfer
  a_one_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted a second request back to back");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_key) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind indexed_min_heap_decrease_key_top hmq_checker u_hmq_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_id, .out_key, .count, .is_empty, .status
);
